// File: rtl/ibs_pkg.sv
// Shared types, constants and the key ordering function for the block sorter.
// Depends on nothing; imported by every module of the sorter.
`default_nettype none

package ibs_pkg;

    // capacity of the cell chain
    localparam int DEPTH = 64;
    localparam int KEY_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SHIFT
    } cell_cmd_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_cmd_t cmd;
        logic      descending;
        key_t      new_key;
    } cell_ctrl_t;

    // true when key a must come after key b in the chosen order
    function automatic logic goes_after(input key_t a, input key_t b, input logic descending);
        logic result;
        if (descending)
        begin
            result = (a < b);
        end
        else
        begin
            result = (a > b);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ibs_cell.sv
// One cell of the insertion chain: holds one key and its occupied bit.
// Depends on ibs_pkg.
`default_nettype none

module ibs_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ibs_pkg::cell_ctrl_t ctrl,
    input  wire ibs_pkg::key_t     prev_key,
    input  wire logic              prev_occ,
    input  wire logic              prev_disp,
    input  wire ibs_pkg::key_t     next_key,
    input  wire logic              next_occ,
    output ibs_pkg::key_t          key,
    output logic                   occ,
    output logic                   disp
);
    import ibs_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic occ_reg;
    logic occ_next;

    // this cell's key must move down to make room for the new one
    assign disp = occ_reg && goes_after(key_reg, ctrl.new_key, ctrl.descending);

    // next contents
    always_comb
    begin
        key_next = key_reg;
        occ_next = occ_reg;
        unique case (ctrl.cmd)
            CMD_INSERT:
            begin
                if (disp)
                begin
                    key_next = prev_disp ? prev_key : ctrl.new_key;
                end
                else if (!occ_reg && prev_occ)
                begin
                    key_next = prev_disp ? prev_key : ctrl.new_key;
                    occ_next = 1'b1;
                end
            end
            CMD_SHIFT:
            begin
                key_next = next_key;
                occ_next = next_occ;
            end
            default:
            begin
                key_next = key_reg;
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;
    assign occ = occ_reg;

endmodule

`default_nettype wire

// File: rtl/ibs_ctrl.sv
// Controller of the sorter: load/drain sequencing, key count, drop flag,
// order register and the output register. Depends on ibs_pkg.
`default_nettype none

module ibs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ibs_pkg::key_t       key_value,
    input  wire logic                is_last_in,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                order_descending,
    input  wire ibs_pkg::key_t       head_key,
    output ibs_pkg::cell_ctrl_t      ctrl,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ibs_pkg::key_t            sorted_key,
    output logic                     is_last_out,
    output logic                     overflow_flag
);
    import ibs_pkg::*;

    state_t state_reg;
    state_t state_next;
    cnt_t   count_reg;
    cnt_t   count_next;
    logic   dropped_reg;
    logic   dropped_next;
    logic   desc_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    key_t   out_key_reg;
    logic   out_last_reg;
    logic   out_ovf_reg;
    logic   in_fire;
    logic   has_room;
    logic   advance;

    assign in_fire  = in_valid && in_ready;
    assign has_room = (count_reg < cnt_t'(DEPTH));
    // output register can take the head cell this cycle
    assign advance  = (state_reg == ST_DRAIN) && (!out_valid_reg || out_ready);

    // next state, count and flags
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + cnt_t'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (is_last_in)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    count_next     = count_reg - cnt_t'(1);
                    if (count_reg == cnt_t'(1))
                    begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // handshake and cell command
    always_comb
    begin
        in_ready        = (state_reg == ST_LOAD);
        cfg_ready       = 1'b1;
        ctrl.new_key    = key_value;
        ctrl.descending = desc_reg;
        ctrl.cmd        = CMD_HOLD;
        if (in_fire && has_room)
        begin
            ctrl.cmd = CMD_INSERT;
        end
        else if (advance)
        begin
            ctrl.cmd = CMD_SHIFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                desc_reg <= order_descending;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_key_reg  <= head_key;
            out_last_reg <= (count_reg == cnt_t'(1));
            out_ovf_reg  <= dropped_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sorted_key    = out_key_reg;
    assign is_last_out   = out_last_reg;
    assign overflow_flag = out_ovf_reg;

endmodule

`default_nettype wire

// File: rtl/integer_block_sorter_unit.sv
// Top level of the block sorter: controller plus a chain of insertion cells.
// Depends on ibs_pkg, ibs_cell and ibs_ctrl.
//
// Usage:
//   Input channel (in_valid/in_ready, key_value, is_last_in) takes one signed
//   key per cycle; is_last_in closes the block. Each key is inserted into a
//   chain of DEPTH cells in the cycle it is accepted, so the chain is always
//   sorted. Keys past DEPTH are dropped and the block's results carry
//   overflow_flag.
//   After the last key, input is held off while the chain shifts toward its
//   head one key per cycle into the output register (out_valid/out_ready,
//   sorted_key, is_last_out, overflow_flag). After the last key is accepted
//   the head key is registered into the output register; keys load and
//   drain one item per cycle each way while the receiver does not stall.
//   If the receiver stalls, the chain and the output register hold.
//   Config channel (cfg_valid/cfg_ready, order_descending) is always ready;
//   write it only while idle. 0 sorts ascending, 1 descending.
//   Reset empties the chain, clears count and drop flag, selects ascending.
`default_nettype none

module integer_block_sorter_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ibs_pkg::key_t key_value,
    input  wire logic          is_last_in,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          order_descending,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ibs_pkg::key_t      sorted_key,
    output logic               is_last_out,
    output logic               overflow_flag
);
    import ibs_pkg::*;

    cell_ctrl_t ctrl;
    key_t       cell_key  [DEPTH];
    logic       cell_occ  [DEPTH];
    logic       cell_disp [DEPTH];

    // sequencing and output register
    ibs_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .key_value        (key_value),
        .is_last_in       (is_last_in),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .order_descending (order_descending),
        .head_key         (cell_key[0]),
        .ctrl             (ctrl),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .sorted_key       (sorted_key),
        .is_last_out      (is_last_out),
        .overflow_flag    (overflow_flag)
    );

    // cell chain, cell 0 holds the first key in output order
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        key_t prev_key;
        logic prev_occ;
        logic prev_disp;
        key_t next_key;
        logic next_occ;

        if (i == 0)
        begin : g_head
            // head sees an occupied, non-moving neighbor: takes the new key
            assign prev_key  = '0;
            assign prev_occ  = 1'b1;
            assign prev_disp = 1'b0;
        end
        else
        begin : g_body
            assign prev_key  = cell_key[i-1];
            assign prev_occ  = cell_occ[i-1];
            assign prev_disp = cell_disp[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            // empty slot shifts in behind the tail
            assign next_key = '0;
            assign next_occ = 1'b0;
        end
        else
        begin : g_inner
            assign next_key = cell_key[i+1];
            assign next_occ = cell_occ[i+1];
        end

        ibs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .prev_key  (prev_key),
            .prev_occ  (prev_occ),
            .prev_disp (prev_disp),
            .next_key  (next_key),
            .next_occ  (next_occ),
            .key       (cell_key[i]),
            .occ       (cell_occ[i]),
            .disp      (cell_disp[i])
        );
    end

endmodule

`default_nettype wire

// File: dv/integer_block_sorter_unit_test.sv
// Testbench for integer_block_sorter_unit: streams key blocks in, predicts the sorted
// output order and overflow marking, and checks every output item in order.
// Depends on ibs_pkg and the integer_block_sorter_unit RTL.
`default_nettype none

module integer_block_sorter_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ibs_pkg::*;

    typedef struct {
        key_t key;
        logic last;
    } key_item_t;

    typedef struct {
        key_t key;
        logic last;
        logic ovf;
    } sorted_item_t;

    localparam key_t KEY_MIN = 32'sh8000_0000;
    localparam key_t KEY_MAX = 32'sh7FFF_FFFF;

    // idling styles
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_ALWAYS = 1;
    localparam int IDLE_SOME   = 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    key_t key_value = '0;
    logic is_last_in = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic order_descending = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    key_t sorted_key;
    logic is_last_out;
    logic overflow_flag;

    // stimulus and prediction state
    key_item_t    pending_keys[$];
    key_t         block_keys[$];
    sorted_item_t due_sorted[$];
    logic         sort_desc = 1'b0;
    logic         block_dropped = 1'b0;
    logic         in_took = 1'b0;
    logic         out_took = 1'b0;
    int           idle_mode = IDLE_NONE;
    int           send_wait = 0;
    int           recv_wait = 0;
    int           hold_left = 0;
    int           n_popped = 0;
    int           n_taken = 0;
    int           mismatch_count = 0;

    integer_block_sorter_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .key_value        (key_value),
        .is_last_in       (is_last_in),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .order_descending (order_descending),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .sorted_key       (sorted_key),
        .is_last_out      (is_last_out),
        .overflow_flag    (overflow_flag)
    );

    always #10 clk = ~clk;

    // idle cycles before the next item, per the current idling style
    function automatic int pick_gap();
        int gap;
        gap = 0;
        if (idle_mode == IDLE_ALWAYS)
        begin
            gap = $urandom_range(0, 19);
        end
        else if (idle_mode == IDLE_SOME && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(0, 19);
        end
        return gap;
    endfunction

    // mix of full-range keys, tight clusters (duplicates) and corner values
    function automatic key_t draw_key();
        key_t k;
        case ($urandom_range(0, 3))
            0: k = key_t'($urandom_range(0, 15)) - 8;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: k = KEY_MIN;
                    1: k = KEY_MAX;
                    2: k = 0;
                    3: k = -1;
                    4: k = KEY_MIN + 1;
                    default: k = KEY_MAX - 1;
                endcase
            end
            default: k = key_t'($urandom());
        endcase
        return k;
    endfunction

    // mostly short blocks, now and then a longer one
    function automatic int draw_size();
        int n;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(9, 40);
        end
        else
        begin
            n = $urandom_range(1, 8);
        end
        return n;
    endfunction

    task automatic add_key(input key_t k, input logic last);
        key_item_t it;
        begin
            it.key = k;
            it.last = last;
            pending_keys.push_back(it);
        end
    endtask

    task automatic add_block(input int n);
        begin
            for (int i = 0; i < n; i++)
            begin
                add_key(draw_key(), i == n - 1);
            end
        end
    endtask

    // keep the key if there is room; on block close emit the sorted block
    task automatic sort_block_keys(input key_t k, input logic last);
        key_t         ordered[$];
        sorted_item_t res;
        int           pos;
        begin
            if (block_keys.size() < ibs_pkg::DEPTH)
            begin
                block_keys.push_back(k);
            end
            else
            begin
                block_dropped = 1'b1;
            end
            if (last)
            begin
                foreach (block_keys[i])
                begin
                    pos = 0;
                    while (pos < ordered.size() &&
                           !(sort_desc ? (ordered[pos] < block_keys[i])
                                       : (ordered[pos] > block_keys[i])))
                    begin
                        pos++;
                    end
                    ordered.insert(pos, block_keys[i]);
                end
                foreach (ordered[i])
                begin
                    res.key = ordered[i];
                    res.last = (i == ordered.size() - 1);
                    res.ovf = block_dropped;
                    due_sorted.push_back(res);
                end
                block_keys.delete();
                block_dropped = 1'b0;
            end
        end
    endtask

    task automatic check_sorted();
        sorted_item_t exp;
        begin
            if (due_sorted.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: unexpected output key %0d last %b ovf %b",
                             $realtime, sorted_key, is_last_out, overflow_flag);
                end
            end
            else
            begin
                exp = due_sorted.pop_front();
                if (sorted_key !== exp.key || is_last_out !== exp.last ||
                    overflow_flag !== exp.ovf)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: expected key %0d last %b ovf %b, got key %0d last %b ovf %b",
                                 $realtime, exp.key, exp.last, exp.ovf,
                                 sorted_key, is_last_out, overflow_flag);
                    end
                end
            end
        end
    endtask

    // sample handshakes on the rising edge, feed the predictor and check outputs
    always @(posedge clk)
    begin
        in_took <= in_valid && in_ready;
        out_took <= out_valid && out_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sort_desc = order_descending;
            end
            if (in_valid && in_ready)
            begin
                n_taken++;
                sort_block_keys(key_value, is_last_in);
            end
            if (out_valid && out_ready)
            begin
                check_sorted();
            end
        end
    end

    // key driver: holds each item until taken, then idles before the next
    always @(negedge clk)
    begin
        key_item_t it;
        if (rst_n)
        begin
            if (in_valid && !in_took)
            begin
                // payload stays put until accepted
            end
            else if (send_wait > 0)
            begin
                in_valid <= 1'b0;
                send_wait--;
            end
            else if (pending_keys.size() > 0)
            begin
                it = pending_keys.pop_front();
                key_value <= it.key;
                is_last_in <= it.last;
                in_valid <= 1'b1;
                n_popped++;
                send_wait = pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output receiver: random stalls per item, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (out_took)
                begin
                    recv_wait = pick_gap();
                end
                if (recv_wait > 0)
                begin
                    recv_wait--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // wait until every key is in and every sorted key is out, then let it settle
    task automatic wait_idle();
        begin
            do
            begin
                @(negedge clk);
            end
            while (pending_keys.size() != 0 || n_taken != n_popped || due_sorted.size() != 0);
            repeat (10) @(negedge clk);
        end
    endtask

    task automatic write_order(input logic desc);
        begin
            wait_idle();
            cfg_valid <= 1'b1;
            order_descending <= desc;
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic run_phase(input logic desc, input int mode, input int n_items,
                             input int first_block);
        int count;
        int n;
        begin
            write_order(desc);
            idle_mode = mode;
            count = 0;
            if (first_block > 0)
            begin
                add_block(first_block);
            end
            while (count < n_items)
            begin
                n = draw_size();
                add_block(n);
                count += n;
            end
        end
    endtask

    // stimulus
    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: lone extremes, corner keys in both orders, equal keys
        write_order(1'b0);
        idle_mode = IDLE_SOME;
        add_key(KEY_MIN, 1'b1);
        add_key(KEY_MAX, 1'b1);
        add_key(KEY_MAX, 1'b0);
        add_key(KEY_MIN, 1'b0);
        add_key(0, 1'b0);
        add_key(-1, 1'b0);
        add_key(1, 1'b0);
        add_key(KEY_MIN, 1'b0);
        add_key(KEY_MAX, 1'b1);
        write_order(1'b1);
        add_key(KEY_MAX, 1'b0);
        add_key(KEY_MIN, 1'b0);
        add_key(0, 1'b0);
        add_key(-1, 1'b0);
        add_key(1, 1'b0);
        add_key(KEY_MIN, 1'b0);
        add_key(KEY_MAX, 1'b1);
        add_key(-1, 1'b1);
        add_key(5, 1'b0);
        add_key(5, 1'b1);

        // random blocks across orders and idling styles
        run_phase(1'b0, IDLE_ALWAYS, 20, 0);
        run_phase(1'b1, IDLE_NONE, 20, 0);

        // back-pressure: receiver stalls long while an overflowing block and more arrive
        write_order(1'b1);
        idle_mode = IDLE_NONE;
        @(posedge clk);
        hold_left = 300;
        add_block(ibs_pkg::DEPTH + 4);
        add_block(3);
        add_block(1);

        // exactly full store, then more random blocks
        run_phase(1'b0, IDLE_SOME, 10, ibs_pkg::DEPTH);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && due_sorted.size() == 0)
        begin
            $display("integer_block_sorter_unit_test: done, clean");
        end
        else
        begin
            $display("integer_block_sorter_unit_test: done, errors");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("integer_block_sorter_unit_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
